@@ design/telemetry_ascii_framer_top_assert.svh @@
// assertion macros for the telemetry ascii framer
`ifndef TELEMETRY_ASCII_FRAMER_TOP_ASSERT_SVH
`define TELEMETRY_ASCII_FRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TAF_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("telemetry framer check failed");
// next-cycle implication
`define TAF_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("telemetry framer check failed");
`else
`define TAF_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define TAF_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

@@ design/taf_pkg.sv @@
// shared constants and types of the telemetry ascii framer
`default_nettype none
package taf_pkg;

	localparam int SPEED_W = 16;
	localparam int ADV_W   = 16;
	localparam int BYTE_W  = 8;

	// range limits for a reading to be framed
	localparam logic [SPEED_W-1:0] SPEED_MAX = 16'd9999;
	localparam logic [ADV_W-1:0]   ADV_MAX   = 16'd999;

	// narrowed widths once the range check passed
	localparam int SPD_NW = 14;
	localparam int ADV_NW = 10;

	localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'h30;
	localparam logic [BYTE_W-1:0] MARK_SPEED = 8'h52;
	localparam logic [BYTE_W-1:0] MARK_ADV   = 8'h41;
	localparam logic [BYTE_W-1:0] LINE_FEED  = 8'h0A;

	localparam int FRAME_LEN = 11;
	localparam int IDX_W     = $clog2(FRAME_LEN);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

	// fixed part of the check byte: both markers plus the ascii offset of six digits
	localparam int SUM_BASE_I = 32'h52 + 32'h41 + 6 * 32'h30;
	localparam logic [BYTE_W-1:0] SUM_BASE = 8'(SUM_BASE_I);

	// reciprocal multipliers, exact for the narrowed operand ranges
	localparam int PROD_W = 28;
	localparam logic [13:0] RECIP_10   = 14'd6554;
	localparam logic [13:0] RECIP_100  = 14'd5243;
	localparam logic [13:0] RECIP_1000 = 14'd8389;
	localparam int SHIFT_10   = 16;
	localparam int SHIFT_100  = 19;
	localparam int SHIFT_1000 = 23;

	typedef struct packed {
		logic [3:0] spd_thou;
		logic [3:0] spd_hund;
		logic [3:0] spd_ten;
		logic [3:0] spd_one;
		logic [3:0] adv_hund;
		logic [3:0] adv_ten;
		logic [3:0] adv_one;
		logic [BYTE_W-1:0] check;
	} frame_t;

endpackage
`default_nettype wire

@@ design/taf_if.sv @@
// stream interfaces for readings in and frame bytes out
`default_nettype none
interface taf_in_if;
	import taf_pkg::*;

	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] rpm;
	logic [ADV_W-1:0]   advance;

	modport source (output valid, output rpm, output advance, input ready);
	modport sink (input valid, input rpm, input advance, output ready);
endinterface

interface taf_out_if;
	import taf_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] frame_byte;
	logic              last;

	modport source (output valid, output frame_byte, output last, input ready);
	modport sink (input valid, input frame_byte, input last, output ready);
endinterface
`default_nettype wire

@@ design/taf_conv.sv @@
// range check and binary to decimal digit conversion with check byte
`default_nettype none
module taf_conv (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic [taf_pkg::SPEED_W-1:0] in_speed,
	input  wire logic [taf_pkg::ADV_W-1:0]   in_adv,
	output      logic                        in_ready,
	output      logic                        out_valid,
	output      taf_pkg::frame_t             out_frame,
	input  wire logic                        out_ready
);
	import taf_pkg::*;

	logic              in_ok;
	logic [SPD_NW-1:0] spd_n;
	logic [ADV_NW-1:0] adv_n;
	logic [PROD_W-1:0] p_s1000, p_s100, p_s10, p_a100, p_a10;

	logic              valid_s2;
	logic [3:0]        q1000_s2;
	logic [6:0]        q100_s2;
	logic [9:0]        q10_s2;
	logic [SPD_NW-1:0] spd_s2;
	logic [3:0]        aq100_s2;
	logic [6:0]        aq10_s2;
	logic [ADV_NW-1:0] adv_s2;

	logic [6:0]        d_hund;
	logic [9:0]        d_ten;
	logic [SPD_NW-1:0] d_one;
	logic [6:0]        a_ten;
	logic [ADV_NW-1:0] a_one;

	assign in_ok = (in_speed <= SPEED_MAX) && (in_adv <= ADV_MAX);
	assign spd_n = in_speed[SPD_NW-1:0];
	assign adv_n = in_adv[ADV_NW-1:0];

	// quotients by constant reciprocal
	assign p_s1000 = PROD_W'(spd_n) * PROD_W'(RECIP_1000);
	assign p_s100  = PROD_W'(spd_n) * PROD_W'(RECIP_100);
	assign p_s10   = PROD_W'(spd_n) * PROD_W'(RECIP_10);
	assign p_a100  = PROD_W'(adv_n) * PROD_W'(RECIP_100);
	assign p_a10   = PROD_W'(adv_n) * PROD_W'(RECIP_10);

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s2 <= in_ok;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			q1000_s2 <= p_s1000[SHIFT_1000 +: 4];
			q100_s2  <= p_s100[SHIFT_100 +: 7];
			q10_s2   <= p_s10[SHIFT_10 +: 10];
			spd_s2   <= spd_n;
			aq100_s2 <= p_a100[SHIFT_100 +: 4];
			aq10_s2  <= p_a10[SHIFT_10 +: 7];
			adv_s2   <= adv_n;
		end
	end

	// each digit below the top one is a quotient less ten times the next coarser quotient
	assign d_hund = q100_s2 - 7'(q1000_s2) * 7'd10;
	assign d_ten  = q10_s2 - 10'(q100_s2) * 10'd10;
	assign d_one  = spd_s2 - SPD_NW'(q10_s2) * SPD_NW'(10);
	assign a_ten  = aq10_s2 - 7'(aq100_s2) * 7'd10;
	assign a_one  = adv_s2 - ADV_NW'(aq10_s2) * ADV_NW'(10);

	always_comb begin
		out_frame.spd_thou = q1000_s2;
		out_frame.spd_hund = d_hund[3:0];
		out_frame.spd_ten  = d_ten[3:0];
		out_frame.spd_one  = d_one[3:0];
		out_frame.adv_hund = aq100_s2;
		out_frame.adv_ten  = a_ten[3:0];
		out_frame.adv_one  = a_one[3:0];
		// last advance digit stays out of the check byte
		out_frame.check = SUM_BASE + 8'(q1000_s2) + 8'(d_hund[3:0]) + 8'(d_ten[3:0])
			+ 8'(d_one[3:0]) + 8'(aq100_s2) + 8'(a_ten[3:0]);
	end

	assign out_valid = valid_s2;
endmodule
`default_nettype wire

@@ design/telemetry_ascii_framer_top.sv @@
// telemetry ascii framer: one reading in, one eleven-byte ascii frame out
// path of a reading: input register, conversion register, frame buffer, output register
// throughput: one frame byte per cycle while the output is taken; the byte serializer sets the pace
// out-of-range readings are dropped in the conversion stage and produce no output
// reset (arst_n low, asynchronous) empties every stage; payload registers keep their contents
`default_nettype none
`include "telemetry_ascii_framer_top_assert.svh"
module telemetry_ascii_framer_top (
	input wire logic clk,
	input wire logic arst_n,
	taf_in_if.sink   sample,
	taf_out_if.source frame
);
	import taf_pkg::*;

	// input register
	logic               valid_s1;
	logic [SPEED_W-1:0] speed_s1;
	logic [ADV_W-1:0]   adv_s1;

	// handshake with the conversion stage
	logic   conv_in_ready;
	logic   conv_valid;
	frame_t conv_frame;

	// frame buffer being serialized
	logic             fr_valid_q;
	frame_t           fr_q;
	logic [IDX_W-1:0] idx_q;

	// output register
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic              out_free;
	logic              emit;
	logic              fr_done;
	logic              fr_ready;
	logic [BYTE_W-1:0] byte_sel;

	// input register is open while empty or while the conversion stage can move
	assign sample.ready = !valid_s1 || conv_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.valid && sample.ready) begin
			valid_s1 <= 1'b1;
		end else if (conv_in_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			speed_s1 <= sample.rpm;
			adv_s1   <= sample.advance;
		end
	end

	// range check drops bad readings, then digits and check byte
	taf_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_speed  (speed_s1),
		.in_adv    (adv_s1),
		.in_ready  (conv_in_ready),
		.out_valid (conv_valid),
		.out_frame (conv_frame),
		.out_ready (fr_ready)
	);

	// a byte moves into the output register whenever that register is empty or being taken
	assign out_free = !out_valid_q || frame.ready;
	assign emit     = fr_valid_q && out_free;
	assign fr_done  = emit && (idx_q == LAST_IDX);
	// next frame loads in the cycle the line feed leaves, so frames run back to back
	assign fr_ready = !fr_valid_q || fr_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_q <= 1'b0;
			idx_q      <= '0;
		end else if (conv_valid && fr_ready) begin
			fr_valid_q <= 1'b1;
			idx_q      <= '0;
		end else if (fr_done) begin
			fr_valid_q <= 1'b0;
			idx_q      <= '0;
		end else if (emit) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (conv_valid && fr_ready) begin
			fr_q <= conv_frame;
		end
	end

	// byte picked by position within the frame
	always_comb begin
		case (idx_q)
			4'd0:    byte_sel = MARK_SPEED;
			4'd1:    byte_sel = DIGIT_BASE + 8'(fr_q.spd_thou);
			4'd2:    byte_sel = DIGIT_BASE + 8'(fr_q.spd_hund);
			4'd3:    byte_sel = DIGIT_BASE + 8'(fr_q.spd_ten);
			4'd4:    byte_sel = DIGIT_BASE + 8'(fr_q.spd_one);
			4'd5:    byte_sel = MARK_ADV;
			4'd6:    byte_sel = DIGIT_BASE + 8'(fr_q.adv_hund);
			4'd7:    byte_sel = DIGIT_BASE + 8'(fr_q.adv_ten);
			4'd8:    byte_sel = DIGIT_BASE + 8'(fr_q.adv_one);
			4'd9:    byte_sel = fr_q.check;
			4'd10:   byte_sel = LINE_FEED;
			default: byte_sel = LINE_FEED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_sel;
			out_last_q <= (idx_q == LAST_IDX);
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.frame_byte = out_byte_q;
	assign frame.last       = out_last_q;

	// the frame always closes on a line feed
	`TAF_ASSERT_IMP(a_last_is_lf, clk, arst_n, frame.valid && frame.last,
		frame.frame_byte == LINE_FEED)
	// bytes of one frame follow without a gap once taken
	`TAF_ASSERT_NXT(a_no_gap, clk, arst_n, frame.valid && frame.ready && !frame.last,
		frame.valid)
	// byte position never runs past the line feed
	`TAF_ASSERT_IMP(a_idx_range, clk, arst_n, fr_valid_q, idx_q <= LAST_IDX)
endmodule
`default_nettype wire
